// ----- rtl/bilinear_grid_coordinate_map_defines.svh -----
// Assertion macros used by the port-level checker of the grid coordinate map.
`ifndef BILINEAR_GRID_COORDINATE_MAP_DEFINES_SVH
`define BILINEAR_GRID_COORDINATE_MAP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define BGCM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define BGCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Delayed implication, sampled on clock, off during reset
`define BGCM_ASSERT_TWO(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

// ----- rtl/bgcm_pkg.sv -----
// Shared constants, codes and types of the grid coordinate map.
package bgcm_pkg;

   // Fixed field widths
   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 22;
   localparam int FRAC_BITS = 16;
   localparam int INT_BITS  = INDEX_W - FRAC_BITS;
   localparam int LOAD_IDX_W = 6;
   localparam int CSR_W     = 7;
   // Dimension compare width, wide enough for the largest grid maximum (1024)
   localparam int DIM_W     = 11;
   localparam int PAIR_W    = 2 * VALUE_W;

   // Payload layout
   localparam int REQ_DATA_W = 2 * LOAD_IDX_W + 2 * VALUE_W + 2 * INDEX_W;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 2 * VALUE_W;
   localparam int RSP_USER_W = 2;

   // Defaults
   localparam int GRID_FIRST_MAX_DEF  = 64;
   localparam int GRID_SECOND_MAX_DEF = 64;
   localparam int DIM_RESET           = 64;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NAN    = 2'd1,
      ST_RANGE  = 2'd2,
      ST_LOADED = 2'd3
   } status_type;

   typedef enum logic {
      CSR_FIRST_DIM  = 1'b0,
      CSR_SECOND_DIM = 1'b1
   } csr_index_type;

endpackage

// ----- rtl/bgcm_grid_ram.sv -----
// Single-port grid memory holding one (x, y) entry pair per word.
module bgcm_grid_ram #(
   parameter int DEPTH  = bgcm_pkg::GRID_FIRST_MAX_DEF * bgcm_pkg::GRID_SECOND_MAX_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [ADDR_W-1:0]           addr,
   input  logic [bgcm_pkg::PAIR_W-1:0] wdata,
   output logic [bgcm_pkg::PAIR_W-1:0] rdata
);

   logic [bgcm_pkg::PAIR_W-1:0] mem [DEPTH];
   logic [bgcm_pkg::PAIR_W-1:0] rdata_ff;

   // Write or read one word a cycle; read data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/bgcm_lerp.sv -----
// Three-stage interpolation step: a + round_half_up((b - a) * f / 2^FRAC_BITS).
module bgcm_lerp (
   input  logic                                clock,
   input  logic signed [bgcm_pkg::VALUE_W-1:0] a,
   input  logic signed [bgcm_pkg::VALUE_W-1:0] b,
   input  logic [bgcm_pkg::FRAC_BITS-1:0]      f,
   output logic signed [bgcm_pkg::VALUE_W-1:0] y
);

   localparam int VW     = bgcm_pkg::VALUE_W;
   localparam int FB     = bgcm_pkg::FRAC_BITS;
   localparam int DIFF_W = VW + 1;
   localparam int PROD_W = DIFF_W + FB + 1;
   localparam int HALF   = 1 << (FB - 1);

   logic signed [DIFF_W-1:0] diff_in, diff_ff;
   logic [FB-1:0]            f_ff;
   logic signed [VW-1:0]     a1_ff, a2_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic [PROD_W-1:0]        rnd_sum;
   logic signed [VW-1:0]     y_in, y_ff;

   // Stage 1: difference of the two end points
   assign diff_in = {b[VW-1], b} - {a[VW-1], a};

   // Stage 2: scale the difference by the fraction
   assign prod_in = diff_ff * $signed({1'b0, f_ff});

   // Stage 3: round half up, drop fraction, add base point
   assign rnd_sum = prod_ff + PROD_W'(HALF);
   assign y_in    = a2_ff + $signed(rnd_sum[FB+VW-1:FB]);

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      f_ff    <= f;
      a1_ff   <= a;
      prod_ff <= prod_in;
      a2_ff   <= a1_ff;
      y_ff    <= y_in;
   end

   assign y = y_ff;

endmodule

// ----- rtl/bilinear_grid_coordinate_map.sv -----
// Bilinear grid coordinate map: two Q16.16 grids (x and y) share one
// single-port memory, one (x, y) pair per word, loaded by load items. A query
// item splits each index into integer part and fraction, reads the four
// corner words, and runs the lower row, upper row and final step through a
// three-stage interpolation unit for x and one for y. A query steps through
// the fetch, capture and finish states before the block is ready again; load,
// not-a-number and out-of-range items go from idle straight to the finish
// state. One item is in work at a time; a finished result waits in the output
// register while the next item is taken. The grid memory is not cleared by
// reset: query only entries that were loaded.
module bilinear_grid_coordinate_map #(
   parameter int GRID_FIRST_MAX  = bgcm_pkg::GRID_FIRST_MAX_DEF,
   parameter int GRID_SECOND_MAX = bgcm_pkg::GRID_SECOND_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Item input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // load_first, load_second, load_x_value, load_y_value, first_index, second_index
   input  logic [bgcm_pkg::REQ_DATA_W-1:0] req_tdata,
   // command, index_is_nan
   input  logic [bgcm_pkg::REQ_USER_W-1:0] req_tuser,
   // Result output
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // x_out, y_out
   output logic [bgcm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [bgcm_pkg::RSP_USER_W-1:0] rsp_tuser,
   // Register writes
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [bgcm_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int DEPTH  = GRID_FIRST_MAX * GRID_SECOND_MAX;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int VW     = bgcm_pkg::VALUE_W;
   localparam int FB     = bgcm_pkg::FRAC_BITS;
   localparam int IB     = bgcm_pkg::INT_BITS;
   localparam int LW     = bgcm_pkg::LOAD_IDX_W;
   localparam int IW     = bgcm_pkg::INDEX_W;
   localparam int DW     = bgcm_pkg::DIM_W;
   localparam int STEP_W = 4;

   // Fetch sequence steps
   localparam logic [STEP_W-1:0] STEP_RD00  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_RD10  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_RD01  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_RD11  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_HIGH  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_LOWQ  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_FINAL = 4'd7;
   localparam logic [STEP_W-1:0] STEP_LAST  = 4'd9;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FETCH = 4'b0010,
      S_CAP   = 4'b0100,
      S_FIN   = 4'b1000
   } state_type;

   // Clamp a dimension register to 1 .. max
   function automatic logic [DW-1:0] eff_dim(input logic [bgcm_pkg::CSR_W-1:0] r,
                                             input int max_v);
      int v;
      v = int'(r);
      if (v == 0) begin
         v = 1;
      end else if (v > max_v) begin
         v = max_v;
      end
      return DW'(v);
   endfunction

   // Word address of grid entry (i, j)
   function automatic logic [ADDR_W-1:0] grid_addr(input logic [LW:0] i,
                                                   input logic [LW:0] j);
      return ADDR_W'(int'(i) * GRID_SECOND_MAX + int'(j));
   endfunction

   // Input fields
   logic                 in_command, in_nan;
   logic [LW-1:0]        in_load_first, in_load_second;
   logic [VW-1:0]        in_load_x, in_load_y;
   logic [IW-1:0]        in_first_index, in_second_index;

   assign in_command      = req_tuser[0];
   assign in_nan          = req_tuser[1];
   assign in_load_first   = req_tdata[LW-1:0];
   assign in_load_second  = req_tdata[2*LW-1:LW];
   assign in_load_x       = req_tdata[2*LW+VW-1:2*LW];
   assign in_load_y       = req_tdata[2*LW+2*VW-1:2*LW+VW];
   assign in_first_index  = req_tdata[2*LW+2*VW+IW-1:2*LW+2*VW];
   assign in_second_index = req_tdata[2*LW+2*VW+2*IW-1:2*LW+2*VW+IW];

   // Configuration registers
   logic [bgcm_pkg::CSR_W-1:0] first_dim_ff, second_dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_dim_ff  <= bgcm_pkg::CSR_W'(bgcm_pkg::DIM_RESET);
         second_dim_ff <= bgcm_pkg::CSR_W'(bgcm_pkg::DIM_RESET);
      end else if (csr_we) begin
         case (csr_index)
            bgcm_pkg::CSR_FIRST_DIM:  first_dim_ff  <= csr_wdata;
            bgcm_pkg::CSR_SECOND_DIM: second_dim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Split the query indexes and check them against the dimensions in use
   logic [IB-1:0] q_i, q_j;
   logic [FB-1:0] q_fi, q_fj;
   logic [DW-1:0] dim1, dim2;
   logic          out_of_range;

   assign q_i  = in_first_index[IW-1:FB];
   assign q_j  = in_second_index[IW-1:FB];
   assign q_fi = in_first_index[FB-1:0];
   assign q_fj = in_second_index[FB-1:0];
   assign dim1 = eff_dim(first_dim_ff, GRID_FIRST_MAX);
   assign dim2 = eff_dim(second_dim_ff, GRID_SECOND_MAX);

   assign out_of_range = (DW'(q_i) >= dim1)
                      || ((q_fi != '0) && (DW'(q_i) + DW'(1) >= dim1))
                      || (DW'(q_j) >= dim2)
                      || ((q_fj != '0) && (DW'(q_j) + DW'(1) >= dim2));

   // Control and datapath registers
   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept, load_in_store, fin_fire;

   logic [IB-1:0]     qi_ff, qj_ff;
   logic [FB-1:0]     fi_ff, fj_ff;
   logic [VW-1:0]     res_x_ff, res_y_ff;
   bgcm_pkg::status_type res_status_ff;
   logic [VW-1:0]     out_x_ff, out_y_ff;
   bgcm_pkg::status_type out_status_ff;

   logic [bgcm_pkg::PAIR_W-1:0] a00_ff, a01_ff, low_ff;
   logic [bgcm_pkg::PAIR_W-1:0] rdata;

   assign req_tready    = (state_ff == S_IDLE);
   assign accept        = req_tvalid && req_tready;
   assign load_in_store = (int'(in_load_first) < GRID_FIRST_MAX)
                       && (int'(in_load_second) < GRID_SECOND_MAX);
   assign fin_fire      = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);

   // Memory port: write on a load item, else corner read by step
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [LW:0]       rd_i, rd_i1, rd_j, rd_j1;

   assign rd_i  = (LW+1)'(qi_ff);
   assign rd_j  = (LW+1)'(qj_ff);
   assign rd_i1 = rd_i + (LW+1)'(1);
   assign rd_j1 = rd_j + (LW+1)'(1);

   assign ram_we = accept && (in_command == bgcm_pkg::CMD_LOAD) && load_in_store;

   always_comb begin
      if (state_ff == S_IDLE) begin
         ram_addr = grid_addr({1'b0, in_load_first}, {1'b0, in_load_second});
      end else begin
         case (step_ff)
            STEP_RD10: ram_addr = grid_addr(rd_i1, rd_j);
            STEP_RD01: ram_addr = grid_addr(rd_i, rd_j1);
            STEP_RD11: ram_addr = grid_addr(rd_i1, rd_j1);
            default:   ram_addr = grid_addr(rd_i, rd_j);
         endcase
      end
   end

   bgcm_grid_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata ({in_load_y, in_load_x}),
      .rdata (rdata)
   );

   // Interpolation operands by step: lower row, upper row, final
   logic [bgcm_pkg::PAIR_W-1:0] lerp_a, lerp_b, lerp_y;
   logic [FB-1:0]               lerp_f;

   always_comb begin
      case (step_ff)
         STEP_RD01: begin
            lerp_a = a00_ff;
            lerp_b = (fi_ff != '0) ? rdata : a00_ff;
            lerp_f = fi_ff;
         end
         STEP_HIGH: begin
            lerp_a = a01_ff;
            lerp_b = (fi_ff != '0) ? rdata : a01_ff;
            lerp_f = fi_ff;
         end
         STEP_FINAL: begin
            lerp_a = low_ff;
            lerp_b = (fj_ff != '0) ? lerp_y : low_ff;
            lerp_f = fj_ff;
         end
         default: begin
            lerp_a = low_ff;
            lerp_b = low_ff;
            lerp_f = fj_ff;
         end
      endcase
   end

   bgcm_lerp u_lerp_x (
      .clock (clock),
      .a     (lerp_a[VW-1:0]),
      .b     (lerp_b[VW-1:0]),
      .f     (lerp_f),
      .y     (lerp_y[VW-1:0])
   );

   bgcm_lerp u_lerp_y (
      .clock (clock),
      .a     (lerp_a[2*VW-1:VW]),
      .b     (lerp_b[2*VW-1:VW]),
      .f     (lerp_f),
      .y     (lerp_y[2*VW-1:VW])
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((in_command == bgcm_pkg::CMD_QUERY) && !in_nan && !out_of_range) begin
                  state_in = S_FETCH;
                  step_in  = STEP_RD00;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FETCH: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = S_CAP;
            end
         end
         S_CAP: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (fin_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = fin_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_RD00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the query and the immediate results
   always_ff @(posedge clock) begin
      if (accept) begin
         qi_ff    <= q_i;
         qj_ff    <= q_j;
         fi_ff    <= q_fi;
         fj_ff    <= q_fj;
         res_x_ff <= '0;
         res_y_ff <= '0;
         if (in_command == bgcm_pkg::CMD_LOAD) begin
            res_status_ff <= bgcm_pkg::ST_LOADED;
         end else if (in_nan) begin
            res_status_ff <= bgcm_pkg::ST_NAN;
         end else if (out_of_range) begin
            res_status_ff <= bgcm_pkg::ST_RANGE;
         end else begin
            res_status_ff <= bgcm_pkg::ST_OK;
         end
      end else if (state_ff == S_CAP) begin
         res_x_ff <= lerp_y[VW-1:0];
         res_y_ff <= lerp_y[2*VW-1:VW];
      end
   end

   // Hold corner words and the lower row result
   always_ff @(posedge clock) begin
      if (state_ff == S_FETCH) begin
         if (step_ff == STEP_RD10) begin
            a00_ff <= rdata;
         end
         if (step_ff == STEP_RD11) begin
            a01_ff <= rdata;
         end
         if (step_ff == STEP_LOWQ) begin
            low_ff <= lerp_y;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (fin_fire) begin
         out_x_ff      <= res_x_ff;
         out_y_ff      <= res_y_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_y_ff, out_x_ff};
   assign rsp_tuser  = out_status_ff;

endmodule

// ----- rtl/bgcm_checker.sv -----
// Port-level checks of the grid coordinate map and their bind.
`include "bilinear_grid_coordinate_map_defines.svh"

module bgcm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [bgcm_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bgcm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [bgcm_pkg::RSP_USER_W-1:0] rsp_tuser
);

   logic req_fire, load_fire, nan_fire;

   assign req_fire  = req_tvalid && req_tready;
   assign load_fire = req_fire && (req_tuser[0] == bgcm_pkg::CMD_LOAD);
   assign nan_fire  = req_fire && (req_tuser[0] == bgcm_pkg::CMD_QUERY) && req_tuser[1];

   // Stalled result item holds
   `BGCM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result item changed")

   // Any status but ok carries zero coordinates
   `BGCM_ASSERT_NOW(a_zero_unless_ok, rsp_tvalid && (rsp_tuser != bgcm_pkg::ST_OK), rsp_tdata == '0, "nonzero coordinates with error status")

   // One item at a time: busy right after an accept
   `BGCM_ASSERT_NEXT(a_one_in_work, req_fire, !req_tready, "item accepted while another is in work")

   // Load item answered via the finish state when the output is free
   `BGCM_ASSERT_TWO(a_load_done, load_fire && !rsp_tvalid, rsp_tvalid && (rsp_tuser == bgcm_pkg::ST_LOADED), "load item not answered with load done")

   // Not-a-number query answered via the finish state when the output is free
   `BGCM_ASSERT_TWO(a_nan_done, nan_fire && !rsp_tvalid, rsp_tvalid && (rsp_tuser == bgcm_pkg::ST_NAN), "not-a-number query not flagged")

endmodule

bind bilinear_grid_coordinate_map bgcm_checker u_bgcm_checker (.*);

// ----- dv/bilinear_grid_coordinate_map_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the grid coordinate map: mirrors the grids and dimensions, predicts each result.
module bilinear_grid_coordinate_map_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // load_first, load_second, load_x_value, load_y_value, first_index, second_index
   input  logic [bgcm_pkg::REQ_DATA_W-1:0] req_tdata,
   // command, index_is_nan
   input  logic [bgcm_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // x_out, y_out
   input  logic [bgcm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   input  logic [bgcm_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [bgcm_pkg::CSR_W-1:0]      csr_wdata,
   output int                              failures,
   output int                              outstanding
);
   import bgcm_pkg::*;

   localparam int SECOND_MAX = GRID_SECOND_MAX_DEF;
   localparam int DEPTH      = GRID_FIRST_MAX_DEF * GRID_SECOND_MAX_DEF;
   localparam longint UNIT   = longint'(1) << FRAC_BITS;

   // Field offsets inside the request payload
   localparam int LS_LO = LOAD_IDX_W;
   localparam int LX_LO = 2 * LOAD_IDX_W;
   localparam int LY_LO = LX_LO + VALUE_W;
   localparam int Q1_LO = LY_LO + VALUE_W;
   localparam int Q2_LO = Q1_LO + INDEX_W;

   typedef struct packed {
      logic [VALUE_W-1:0] x;
      logic [VALUE_W-1:0] y;
      status_type         status;
   } map_result_type;

   bit [VALUE_W-1:0] x_grid [DEPTH];
   bit [VALUE_W-1:0] y_grid [DEPTH];
   int               dim_first  = DIM_RESET;
   int               dim_second = DIM_RESET;
   map_result_type   awaited_results [$];
   int               mismatches = 0;

   // Zero acts as one point, anything above the grid size as the full grid
   function automatic int clamp_dim(int v, int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic longint grid_entry(bit use_y, int i, int j);
      int k;
      k = i * SECOND_MAX + j;
      if (k >= DEPTH) return 0;
      return use_y ? longint'($signed(y_grid[k])) : longint'($signed(x_grid[k]));
   endfunction

   // One weighted step between a and b, rounded to nearest with halves upward
   function automatic longint blend(longint a, longint b, longint f);
      return (a * (UNIT - f) + b * f + UNIT / 2) >>> FRAC_BITS;
   endfunction

   // Lower and upper rows along the first index, then along the second
   function automatic logic [VALUE_W-1:0] warp(bit use_y, int i, int j, longint fi, longint fj);
      longint a00, a10, a01, a11, low, high, v;
      a00 = grid_entry(use_y, i, j);
      a10 = (fi != 0) ? grid_entry(use_y, i + 1, j) : a00;
      low = blend(a00, a10, fi);
      high = low;
      if (fj != 0) begin
         a01 = grid_entry(use_y, i, j + 1);
         a11 = (fi != 0) ? grid_entry(use_y, i + 1, j + 1) : a01;
         high = blend(a01, a11, fi);
      end
      v = blend(low, high, fj);
      return v[VALUE_W-1:0];
   endfunction

   // Apply one item to the mirrored grids and return the result it should give
   function automatic map_result_type map_item(logic [REQ_DATA_W-1:0] data,
                                               logic [REQ_USER_W-1:0] user);
      map_result_type     res;
      logic [INDEX_W-1:0] q1, q2;
      int                 lf, ls, i1, i2, d1, d2, k;
      longint             f1, f2;
      res.x = '0;
      res.y = '0;
      res.status = ST_OK;
      if (command_type'(user[0]) == CMD_LOAD) begin
         lf = int'(data[LOAD_IDX_W-1:0]);
         ls = int'(data[LS_LO +: LOAD_IDX_W]);
         if (lf < GRID_FIRST_MAX_DEF && ls < GRID_SECOND_MAX_DEF) begin
            k = lf * SECOND_MAX + ls;
            x_grid[k] = data[LX_LO +: VALUE_W];
            y_grid[k] = data[LY_LO +: VALUE_W];
         end
         res.status = ST_LOADED;
         return res;
      end
      if (user[1]) begin
         res.status = ST_NAN;
         return res;
      end
      q1 = data[Q1_LO +: INDEX_W];
      q2 = data[Q2_LO +: INDEX_W];
      i1 = int'(q1[INDEX_W-1:FRAC_BITS]);
      i2 = int'(q2[INDEX_W-1:FRAC_BITS]);
      f1 = longint'(q1[FRAC_BITS-1:0]);
      f2 = longint'(q2[FRAC_BITS-1:0]);
      d1 = clamp_dim(dim_first, GRID_FIRST_MAX_DEF);
      d2 = clamp_dim(dim_second, GRID_SECOND_MAX_DEF);
      if (i1 >= d1 || (f1 != 0 && i1 + 1 >= d1) || i2 >= d2 || (f2 != 0 && i2 + 1 >= d2)) begin
         res.status = ST_RANGE;
         return res;
      end
      res.x = warp(1'b0, i1, i2, f1, f2);
      res.y = warp(1'b1, i1, i2, f1, f2);
      return res;
   endfunction

   // Track register writes and items, compare each result with the oldest prediction
   always @(posedge clock) begin
      map_result_type want, got;
      if (reset) begin
         dim_first = DIM_RESET;
         dim_second = DIM_RESET;
         awaited_results.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_FIRST_DIM) dim_first = int'(csr_wdata);
            else dim_second = int'(csr_wdata);
         end
         if (req_tvalid && req_tready) awaited_results.push_back(map_item(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            got.x = rsp_tdata[VALUE_W-1:0];
            got.y = rsp_tdata[2*VALUE_W-1:VALUE_W];
            got.status = status_type'(rsp_tuser);
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: x %h y %h status %0d", got.x, got.y, got.status);
            end else begin
               want = awaited_results.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected x %h y %h status %0d, got x %h y %h status %0d",
                              want.x, want.y, want.status, got.x, got.y, got.status);
               end
            end
         end
      end
      failures <= mismatches;
      outstanding <= awaited_results.size();
   end

endmodule

// ----- dv/bilinear_grid_coordinate_map_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the grid coordinate map: drives loads, queries and dimension writes.
module bilinear_grid_coordinate_map_test;
   import bgcm_pkg::*;

   localparam int GRID_SIDE     = GRID_FIRST_MAX_DEF;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int DIRECTED_ITEMS = 40;
   localparam int PHASES        = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT_ITEM  = 700;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we = 1'b0;
   logic                  csr_index = 1'b0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   int failures;
   int outstanding;
   int cycle_count = 0;
   int items_sent = 0;
   bit calm = 1'b0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit loaded [GRID_SIDE * GRID_SIDE];
   int dim1 = DIM_RESET;
   int dim2 = DIM_RESET;
   int n_loads = 0;
   int n_blends = 0;
   int n_hits = 0;
   int n_range = 0;
   int n_nan = 0;

   always #1 clock = ~clock;

   bilinear_grid_coordinate_map uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bilinear_grid_coordinate_map_checker map_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: random stalls, one long hold-off to back the block up
   always @(posedge clock) begin
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 25);
      end
   end

   function automatic int dim_in_use(int v);
      if (v == 0) return 1;
      if (v > GRID_SIDE) return GRID_SIDE;
      return v;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // Index inside the points in use; the last point only without a fraction
   function automatic logic [INDEX_W-1:0] index_within(int d, bit whole);
      int               i;
      logic [FRAC_BITS-1:0] f;
      i = $urandom_range(d - 1);
      if (whole || i == d - 1 || $urandom_range(3) == 0) f = '0;
      else f = FRAC_BITS'($urandom);
      return {INT_BITS'(i), f};
   endfunction

   // Index past the points in use, or on the last point with a fraction
   function automatic logic [INDEX_W-1:0] index_beyond(int d);
      int               i;
      logic [FRAC_BITS-1:0] f;
      if (d < GRID_SIDE && $urandom_range(1) == 1) begin
         i = $urandom_range(GRID_SIDE - 1, d);
         f = FRAC_BITS'($urandom);
      end else begin
         i = d - 1;
         f = FRAC_BITS'($urandom_range(65535, 1));
      end
      return {INT_BITS'(i), f};
   endfunction

   // Offer one item after a random gap and hold it until accepted
   task automatic push_item(command_type cmd, bit nan_flag,
                            logic [LOAD_IDX_W-1:0] lf, logic [LOAD_IDX_W-1:0] ls,
                            logic [VALUE_W-1:0] lx, logic [VALUE_W-1:0] ly,
                            logic [INDEX_W-1:0] q1, logic [INDEX_W-1:0] q2);
      while (!calm && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {q2, q1, ly, lx, ls, lf};
      req_tuser <= {nan_flag, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      calm = (items_sent >= 250 && items_sent < 450);
   endtask

   task automatic load_entry(logic [LOAD_IDX_W-1:0] a, logic [LOAD_IDX_W-1:0] b,
                             logic [VALUE_W-1:0] xv, logic [VALUE_W-1:0] yv);
      loaded[int'(a) * GRID_SIDE + int'(b)] = 1'b1;
      n_loads++;
      push_item(CMD_LOAD, 1'($urandom), a, b, xv, yv, INDEX_W'($urandom), INDEX_W'($urandom));
   endtask

   // Load any corner not yet written, then ask for the point
   task automatic query_at(logic [INDEX_W-1:0] q1, logic [INDEX_W-1:0] q2);
      int i1, i2;
      i1 = int'(q1[INDEX_W-1:FRAC_BITS]);
      i2 = int'(q2[INDEX_W-1:FRAC_BITS]);
      for (int a = i1; a <= i1 + 1; a++)
         for (int b = i2; b <= i2 + 1; b++)
            if (a < GRID_SIDE && b < GRID_SIDE && !loaded[a * GRID_SIDE + b])
               load_entry(LOAD_IDX_W'(a), LOAD_IDX_W'(b), pick_value(), pick_value());
      if (q1[FRAC_BITS-1:0] == 0 && q2[FRAC_BITS-1:0] == 0) n_hits++;
      else n_blends++;
      push_item(CMD_QUERY, 1'b0, LOAD_IDX_W'($urandom), LOAD_IDX_W'($urandom),
                $urandom, $urandom, q1, q2);
   endtask

   task automatic query_outside(logic [INDEX_W-1:0] q1, logic [INDEX_W-1:0] q2);
      n_range++;
      push_item(CMD_QUERY, 1'b0, LOAD_IDX_W'($urandom), LOAD_IDX_W'($urandom),
                $urandom, $urandom, q1, q2);
   endtask

   task automatic query_nan(logic [INDEX_W-1:0] q1, logic [INDEX_W-1:0] q2);
      n_nan++;
      push_item(CMD_QUERY, 1'b1, LOAD_IDX_W'($urandom), LOAD_IDX_W'($urandom),
                $urandom, $urandom, q1, q2);
   endtask

   // Drain the block, let it settle, then write both dimensions
   task automatic set_dims(int first, int second);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_FIRST_DIM;
      csr_wdata <= CSR_W'(first);
      @(posedge clock);
      csr_index <= CSR_SECOND_DIM;
      csr_wdata <= CSR_W'(second);
      @(posedge clock);
      csr_we <= 1'b0;
      dim1 = dim_in_use(first);
      dim2 = dim_in_use(second);
   endtask

   initial begin
      int phase_end, pick, d_first, d_second;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extreme entries around both grid corners, full reset dimensions
      load_entry(6'd0, 6'd0, 32'h8000_0000, 32'h7fff_ffff);
      load_entry(6'd1, 6'd0, 32'h7fff_ffff, 32'h8000_0000);
      load_entry(6'd0, 6'd1, 32'h0000_0000, 32'hffff_ffff);
      load_entry(6'd1, 6'd1, 32'h0000_0001, 32'h0000_0000);
      load_entry(6'd63, 6'd63, 32'h7fff_ffff, 32'h8000_0000);
      load_entry(6'd62, 6'd63, 32'hffff_0000, 32'h0001_0000);
      load_entry(6'd63, 6'd62, 32'h8000_0000, 32'h7fff_ffff);
      load_entry(6'd62, 6'd62, 32'h0000_0000, 32'hffff_ffff);
      // Exact hits, half-way rounding, smallest and largest fractions
      query_at(22'h0, 22'h0);
      query_at({6'd0, 16'h8000}, 22'h0);
      query_at({6'd0, 16'h8000}, {6'd0, 16'h8000});
      query_at({6'd0, 16'hffff}, {6'd0, 16'hffff});
      query_at({6'd0, 16'h0001}, {6'd0, 16'h0001});
      query_at({6'd0, 16'h0000}, {6'd1, 16'h0000});
      query_at({6'd63, 16'h0000}, {6'd63, 16'h0000});
      query_at({6'd62, 16'h4000}, {6'd62, 16'hc000});
      // Fraction on the last point, then the largest indexes
      query_outside({6'd63, 16'h0001}, 22'h0);
      query_outside(22'h0, {6'd63, 16'h8000});
      query_outside(22'h3fffff, 22'h3fffff);
      // Not-a-number wins over any index
      query_nan(22'h0, 22'h0);
      query_nan(22'h3fffff, 22'h3fffff);

      // Random phases, each under its own dimension setting
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin d_first = 1;   d_second = 64;  end
            1: begin d_first = 64;  d_second = 1;   end
            2: begin d_first = 0;   d_second = 127; end
            3: begin d_first = 127; d_second = 0;   end
            4, 5: begin
               d_first = $urandom_range(63, 2);
               d_second = $urandom_range(63, 2);
            end
            6: begin d_first = 1;   d_second = 1;   end
            default: begin d_first = 64; d_second = 64; end
         endcase
         set_dims(d_first, d_second);
         phase_end = DIRECTED_ITEMS + (RANDOM_ITEMS - DIRECTED_ITEMS) * (p + 1) / PHASES;
         while (items_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 30)
               load_entry(LOAD_IDX_W'($urandom), LOAD_IDX_W'($urandom), pick_value(), pick_value());
            else if (pick < 65)
               query_at(index_within(dim1, 1'b0), index_within(dim2, 1'b0));
            else if (pick < 75)
               query_at(index_within(dim1, 1'b1), index_within(dim2, 1'b1));
            else if (pick < 88) begin
               if ($urandom_range(1) == 1) query_outside(index_beyond(dim1), INDEX_W'($urandom));
               else query_outside(index_within(dim1, 1'b0), index_beyond(dim2));
            end else
               query_nan(INDEX_W'($urandom), INDEX_W'($urandom));
         end
      end

      // Drain and settle before the verdict
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d loads, %0d blended and %0d exact-hit queries, %0d out of range, %0d nan",
               n_loads, n_blends, n_hits, n_range, n_nan);
      $display("across %0d dimension settings with a %0d-cycle result stall, %0d mismatches",
               PHASES + 1, HOLD_CYCLES, failures);
      if (failures == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bgcm_pkg.sv
rtl/bgcm_grid_ram.sv
rtl/bgcm_lerp.sv
rtl/bilinear_grid_coordinate_map.sv
rtl/bgcm_checker.sv
dv/bilinear_grid_coordinate_map_checker.sv
dv/bilinear_grid_coordinate_map_test.sv
